### hw/rtl/quaternion_normalizer_core_macros.svh
// Assertion macros shared by the quaternion normalizer RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef QUATERNION_NORMALIZER_CORE_MACROS_SVH
`define QUATERNION_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/qn_pkg.sv
// Shared constants and types of the quaternion normalizer.
// Used by every module of the block; depends on nothing.
package qn_pkg;

	localparam int CW    = 16;            // component width
	localparam int FRAC  = CW - 2;        // fraction bits
	localparam int NB    = FRAC + 1;      // bits of a result magnitude
	localparam int SQW   = 2 * CW - 1;    // square of one magnitude
	localparam int SW    = 2 * CW + 1;    // sum of four squares
	localparam int QD    = 4;             // queue depth
	localparam int QAW   = $clog2(QD);

	// One classified item between the front and the back.
	typedef struct packed {
		logic [3:0][SQW-1:0] sq;
		logic [SW-1:0]       s;
		logic [3:0]          neg;
		logic                zero;
	} qn_item_t;

endpackage

### hw/rtl/qn_front.sv
// Front end: takes input beats, forms magnitudes, squares and their sum.
// Depends on qn_pkg.
module qn_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [4*qn_pkg::CW-1:0] in_data,
	output logic                  item_valid,
	input  logic                  item_ready,
	output qn_pkg::qn_item_t      item
);

	logic                        v_s1, v_s2;
	logic [3:0][qn_pkg::CW-1:0]  mag_s1;
	logic [3:0]                  neg_s1, neg_s2;
	logic [3:0][qn_pkg::SQW-1:0] sq_s2;
	logic                        en;
	logic [qn_pkg::SW-1:0]       sum;

	assign en       = !v_s2 || item_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				logic [qn_pkg::CW-1:0] v;
				v = in_data[l*qn_pkg::CW +: qn_pkg::CW];
				neg_s1[l] <= v[qn_pkg::CW-1];
				mag_s1[l] <= v[qn_pkg::CW-1] ? (~v + 1'b1) : v;
				sq_s2[l]  <= qn_pkg::SQW'(mag_s1[l]) * qn_pkg::SQW'(mag_s1[l]);
			end
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		sum = '0;
		for (int l = 0; l < 4; l++) begin
			sum = sum + qn_pkg::SW'(sq_s2[l]);
		end
	end

	assign item_valid = v_s2;
	assign item.sq    = sq_s2;
	assign item.s     = sum;
	assign item.neg   = neg_s2;
	assign item.zero  = (sum == '0);

endmodule

### hw/rtl/qn_fifo.sv
// Short queue that decouples the front end from the search pipeline.
// Depends on qn_pkg and the assertion macro header.
`include "quaternion_normalizer_core_macros.svh"
module qn_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  qn_pkg::qn_item_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output qn_pkg::qn_item_t pop_item
);

	qn_pkg::qn_item_t       mem_q [qn_pkg::QD];
	logic [qn_pkg::QAW-1:0] wp_q, rp_q;
	logic [qn_pkg::QAW:0]   cnt_q;
	logic                   push, pop;

	assign push_ready = (cnt_q != (qn_pkg::QAW+1)'(qn_pkg::QD));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (qn_pkg::QAW+1)'(push) - (qn_pkg::QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	`QN_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= (qn_pkg::QAW+1)'(qn_pkg::QD), "queue count exceeds depth")
	`QN_ASSERT_NEXT(a_cnt_track, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")
	`QN_ASSERT_NEXT(a_cnt_drain, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue count did not shrink on pop")

endmodule

### hw/rtl/qn_back.sv
// Back end: bit-serial exact search of each rounded normalized magnitude,
// one result bit per stage for all four lanes, then sign and output register.
// Depends on qn_pkg and the assertion macro header.
`include "quaternion_normalizer_core_macros.svh"
module qn_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  qn_pkg::qn_item_t          item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [4*qn_pkg::CW-1:0]   out_data,
	output logic                      out_zero
);

	localparam int NB = qn_pkg::NB;
	localparam int SW = qn_pkg::SW;
	localparam int RW = qn_pkg::SQW + 2 * qn_pkg::FRAC + 2;
	localparam int QW = 2 * NB + 3 + SW;
	localparam int PW = NB + 2 + SW;

	// Q holds (2n-1)^2*S and P holds (2n-1)*S for the bits settled so far.
	typedef struct packed {
		logic [SW-1:0]         s;
		logic [3:0][RW-1:0]    r;
		logic [3:0][QW-1:0]    q;
		logic [3:0][PW-1:0]    p;
		logic [3:0][NB-1:0]    n;
		logic [3:0]            neg;
		logic                  zero;
	} qn_work_t;

	qn_work_t                st_s [NB+1];
	qn_work_t                nxt  [NB];
	qn_work_t                load;
	logic [NB:0]             vld_s;
	logic                    en;
	logic [4*qn_pkg::CW-1:0] data_q;
	logic                    zero_q, valid_q;

	assign en         = !valid_q || out_ready;
	assign item_ready = en;

	always_comb begin
		load.s    = item.s;
		load.neg  = item.neg;
		load.zero = item.zero;
		for (int l = 0; l < 4; l++) begin
			load.r[l] = RW'(item.sq[l]) << (2 * qn_pkg::FRAC + 2);
			load.q[l] = QW'(item.s);
			load.p[l] = -PW'(item.s);
			load.n[l] = '0;
		end
	end

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			nxt[j] = st_s[j];
			for (int l = 0; l < 4; l++) begin
				logic [QW-1:0] pext, trial;
				pext  = {{(QW-PW){st_s[j].p[l][PW-1]}}, st_s[j].p[l]};
				trial = st_s[j].q[l] + (pext << (NB - 1 - j + 2))
				        + (QW'(st_s[j].s) << (2 * (NB - 1 - j) + 2));
				if ($signed(trial) <= $signed(QW'(st_s[j].r[l]))) begin
					nxt[j].q[l]          = trial;
					nxt[j].p[l]          = st_s[j].p[l] + (PW'(st_s[j].s) << (NB - j));
					nxt[j].n[l][NB-1-j]  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			valid_q <= 1'b0;
		end else if (en) begin
			vld_s   <= {vld_s[NB-1:0], item_valid};
			valid_q <= vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= load;
			for (int j = 1; j <= NB; j++) begin
				st_s[j] <= nxt[j-1];
			end
			for (int l = 0; l < 4; l++) begin
				logic [NB-1:0]         m;
				logic [qn_pkg::CW-1:0] v;
				m = st_s[NB].n[l];
				if (m > NB'(1 << qn_pkg::FRAC)) m = NB'(1 << qn_pkg::FRAC);
				v = qn_pkg::CW'(m);
				if (st_s[NB].zero) v = '0;
				else if (st_s[NB].neg[l]) v = ~v + 1'b1;
				data_q[l*qn_pkg::CW +: qn_pkg::CW] <= v;
			end
			zero_q <= st_s[NB].zero;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_zero  = zero_q;

	`QN_ASSERT_NOW(a_zero_data, clk, arst_n, valid_q && zero_q, data_q == '0, "zero flag with nonzero data")
	`QN_ASSERT_NOW(a_w_bound, clk, arst_n, valid_q, ($signed(data_q[qn_pkg::CW-1:0]) <= $signed(qn_pkg::CW'(1 << qn_pkg::FRAC))) && ($signed(data_q[qn_pkg::CW-1:0]) >= -$signed(qn_pkg::CW'(1 << qn_pkg::FRAC))), "scalar result out of unit range")
	`QN_ASSERT_NEXT(a_hold_pipe, clk, arst_n, !en, $stable(vld_s), "pipeline moved while stalled")

endmodule

### hw/rtl/quaternion_normalizer_core.sv
// Top level of the quaternion normalizer.
// Depends on qn_pkg, qn_front, qn_fifo and qn_back.
//
// Normalizes one Q2.14 quaternion per beat to unit length. Each output
// component is the input component times 2^14 divided by the exact square
// root of the sum of the squared components, rounded to nearest with ties
// away from zero and held to +/-16384. An all-zero input yields zeros with
// the zero_norm flag on m_tuser. The block accepts a new quaternion every
// clock cycle while the master side does not stall and returns one result
// beat per input beat, in order. A beat passes two front stages (magnitude,
// then the squares and their sum), the four-entry queue, a load stage,
// fifteen search stages that settle one result bit each for all four
// components, and the output register. Stalls on the master side back up
// through the queue and then the front, without losing or repeating a beat.
module quaternion_normalizer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// s_tdata from bit 0 up: w_in, x_in, y_in, z_in
	input  logic [4*qn_pkg::CW-1:0]     s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// m_tdata from bit 0 up: w_out, x_out, y_out, z_out
	output logic [4*qn_pkg::CW-1:0]     m_tdata,
	// m_tuser: zero_norm
	output logic                        m_tuser
);

	qn_pkg::qn_item_t push_item, pop_item;
	logic             push_valid, push_ready, pop_valid, pop_ready;

	// Front end: classify each quaternion and form the sum of squares.
	qn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.item_valid (push_valid),
		.item_ready (push_ready),
		.item       (push_item)
	);

	// Queue so that front and back can stall independently.
	qn_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: exact rounded division by the square root, bit by bit.
	qn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_zero   (m_tuser)
	);

endmodule
